// File: src/pnbh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Nibble bigram histogram package
// Shared constants, operation codes and the command format that travels from
// the front end to the counter back end.
// ----------------------------------------------------------------------------
package pnbh_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;

  localparam int SYMBOL_COUNT = 16;
  localparam int NIB_W        = $clog2(SYMBOL_COUNT);
  localparam int CELL_W       = 2 * NIB_W;
  localparam int CELL_COUNT   = SYMBOL_COUNT * SYMBOL_COUNT;

  localparam int NUM_LAYERS = 3;
  localparam int NUM_KINDS  = 3;

  // Pair kinds, each counted in a bank of its own.
  localparam int KIND_BYTE  = 0;  // high then low nibble of the current byte
  localparam int KIND_CROSS = 1;  // previous low nibble then current high nibble
  localparam int KIND_HELD  = 2;  // high then low nibble of the held first byte

  localparam int              OUT_W   = 18;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  localparam int CMD_QUEUE_DEPTH = 4;
  localparam int OUT_QUEUE_DEPTH = 4;
  localparam int OUT_COUNT_W     = $clog2(OUT_QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] LAYER_UNUSED = 2'd3;

  localparam logic [1:0] SEL_SUM = 2'd0;
  localparam logic [1:0] SEL_L3  = 2'd1;
  localparam logic [1:0] SEL_L4  = 2'd2;
  localparam logic [1:0] SEL_L7  = 2'd3;

  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_HELD = 2'd1;
  localparam logic [1:0] PHASE_RUN  = 2'd2;

  typedef enum logic [1:0] {
    CMD_BUMP,
    CMD_READ,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                       kind;
    logic [1:0]                      layer;
    logic [NUM_KINDS-1:0]            en;
    logic [NUM_KINDS-1:0][CELL_W-1:0] addr;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage
`default_nettype wire

// File: src/pnbh_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pnbh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/pnbh_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Small register FIFO
// Holds commands between front and back end, and results before the output.
// ----------------------------------------------------------------------------
module pnbh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       full,
  output logic                       empty
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign pop_data = mem[rd_ptr];
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

endmodule
`default_nettype wire

// File: src/pnbh_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Histogram front end
// Accepts transactions, tracks the open segment and turns reads, clears and
// each later byte of a counted segment into a command naming cells to bump.
// ----------------------------------------------------------------------------
module pnbh_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    op,
  input  logic [7:0]    data_byte,
  input  logic [1:0]    layer,
  input  logic          segment_start,
  input  logic [3:0]    row_nibble,
  input  logic [3:0]    col_nibble,
  input  logic          queue_full,
  input  logic          init_busy,
  output logic          cmd_push,
  output pnbh_pkg::cmd_t cmd
);

  import pnbh_pkg::*;

  logic [7:0] held_byte;
  logic [7:0] held_byte_next;
  logic [3:0] prev_lo;
  logic [3:0] prev_lo_next;
  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [1:0] cur_layer;
  logic [1:0] cur_layer_next;
  logic       accept;

  assign in_ready = !queue_full && !init_busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    held_byte_next = held_byte;
    prev_lo_next   = prev_lo;
    phase_next     = phase;
    cur_layer_next = cur_layer;
    cmd_push       = 1'b0;
    cmd            = '0;
    cmd.kind       = CMD_BUMP;
    if (accept) begin
      case (op)
        OP_DATA: begin
          if (segment_start || phase == PHASE_IDLE) begin
            // A lone first byte forms no pair yet; keep it for later.
            held_byte_next = data_byte;
            prev_lo_next   = data_byte[3:0];
            cur_layer_next = layer;
            phase_next     = PHASE_HELD;
          end else begin
            cmd.kind             = CMD_BUMP;
            cmd.layer            = cur_layer;
            cmd.addr[KIND_BYTE]  = data_byte;
            cmd.addr[KIND_CROSS] = {prev_lo, data_byte[7:4]};
            cmd.addr[KIND_HELD]  = held_byte;
            cmd.en[KIND_BYTE]    = 1'b1;
            cmd.en[KIND_CROSS]   = 1'b1;
            cmd.en[KIND_HELD]    = (phase == PHASE_HELD);
            cmd_push             = (cur_layer != LAYER_UNUSED);
            prev_lo_next         = data_byte[3:0];
            phase_next           = PHASE_RUN;
          end
        end
        OP_READ: begin
          cmd.kind            = CMD_READ;
          cmd.addr[KIND_BYTE] = {row_nibble, col_nibble};
          cmd_push            = 1'b1;
        end
        OP_CLEAR: begin
          cmd.kind = CMD_CLEAR;
          cmd_push = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte <= '0;
      prev_lo   <= '0;
      phase     <= PHASE_IDLE;
      cur_layer <= '0;
    end else begin
      held_byte <= held_byte_next;
      prev_lo   <= prev_lo_next;
      phase     <= phase_next;
      cur_layer <= cur_layer_next;
    end
  end

endmodule
`default_nettype wire

// File: src/pnbh_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Histogram back end
// Nine counter RAMs (three layers by three pair kinds), a two-stage
// read-modify-write path with write forwarding, the readout adder and the
// clearing sweep.
// ----------------------------------------------------------------------------
module pnbh_back #(
  parameter int COUNT_WIDTH = pnbh_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  pnbh_pkg::cmd_t               cmd,
  output logic                         cmd_pop,
  input  logic [1:0]                   readout_select,
  input  logic [pnbh_pkg::OUT_COUNT_W-1:0] res_count,
  output logic                         res_push,
  output logic [pnbh_pkg::OUT_W-1:0]   res_data,
  output logic                         init_busy
);

  import pnbh_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam int LSUM_W = COUNT_WIDTH + 2;
  localparam int EXT_W  = (LSUM_W > OUT_W) ? LSUM_W : OUT_W;
  localparam int CR_W   = OUT_COUNT_W + 1;

  logic              sweep_active;
  logic              sweep_init;
  logic [CELL_W-1:0] sweep_row;

  logic w_valid;
  cmd_t w_cmd;
  logic w_is_read;

  logic                   s_valid;
  logic [COUNT_WIDTH-1:0] s_layer [NUM_LAYERS];

  logic [COUNT_WIDTH-1:0] rdata     [NUM_LAYERS][NUM_KINDS];
  logic [COUNT_WIDTH-1:0] fwd       [NUM_LAYERS][NUM_KINDS];
  logic [COUNT_WIDTH-1:0] wdata     [NUM_LAYERS][NUM_KINDS];
  logic [CELL_W-1:0]      waddr     [NUM_LAYERS][NUM_KINDS];
  logic [CELL_W-1:0]      issue_addr[NUM_LAYERS][NUM_KINDS];
  logic [CELL_W-1:0]      w_addr    [NUM_LAYERS][NUM_KINDS];
  logic                   we        [NUM_LAYERS][NUM_KINDS];
  logic                   last_we   [NUM_LAYERS][NUM_KINDS];
  logic [CELL_W-1:0]      last_addr [NUM_LAYERS][NUM_KINDS];
  logic [COUNT_WIDTH-1:0] last_data [NUM_LAYERS][NUM_KINDS];

  logic [LSUM_W-1:0]      lsum  [NUM_LAYERS];
  logic [COUNT_WIDTH-1:0] lclamp[NUM_LAYERS];

  logic [CR_W-1:0]  credit_used;
  logic             credit_ok;
  logic [EXT_W-1:0] total;
  logic [EXT_W-1:0] pick;

  assign w_is_read = w_valid && (w_cmd.kind == CMD_READ);

  // Results in flight plus results queued must fit the output queue.
  assign credit_used = CR_W'(res_count) + CR_W'(w_is_read) + CR_W'(s_valid);
  assign credit_ok   = credit_used < CR_W'(OUT_QUEUE_DEPTH);

  assign cmd_pop   = cmd_valid && !sweep_active && ((cmd.kind != CMD_READ) || credit_ok);
  assign init_busy = sweep_active && sweep_init;

  for (genvar l = 0; l < NUM_LAYERS; l++) begin : g_layer
    for (genvar k = 0; k < NUM_KINDS; k++) begin : g_kind
      logic bump_hit;

      assign issue_addr[l][k] = (cmd.kind == CMD_READ) ? cmd.addr[KIND_BYTE] : cmd.addr[k];
      assign w_addr[l][k]     = (w_cmd.kind == CMD_READ) ? w_cmd.addr[KIND_BYTE]
                                                         : w_cmd.addr[k];

      // The RAM read misses a write made in the cycle of the read.
      assign fwd[l][k] = (last_we[l][k] && last_addr[l][k] == w_addr[l][k]) ?
                         last_data[l][k] : rdata[l][k];

      assign bump_hit = w_valid && (w_cmd.kind == CMD_BUMP) && w_cmd.en[k] &&
                        (w_cmd.layer == 2'(l));

      assign we[l][k]    = sweep_active || bump_hit;
      assign waddr[l][k] = sweep_active ? sweep_row : w_addr[l][k];
      assign wdata[l][k] = sweep_active ? '0 :
                           (fwd[l][k] == CNT_MAX) ? fwd[l][k] :
                           fwd[l][k] + COUNT_WIDTH'(1);

      pnbh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (CELL_COUNT)
      ) u_ram (
        .clk   (clk),
        .we    (we[l][k]),
        .waddr (waddr[l][k]),
        .wdata (wdata[l][k]),
        .raddr (issue_addr[l][k]),
        .rdata (rdata[l][k])
      );

      always_ff @(posedge clk) begin
        if (rst) begin
          last_we[l][k] <= 1'b0;
        end else begin
          last_we[l][k] <= we[l][k];
        end
      end

      always_ff @(posedge clk) begin
        last_addr[l][k] <= waddr[l][k];
        last_data[l][k] <= wdata[l][k];
      end
    end

    // The three kind banks saturate on their own, so clamping their sum at
    // the counter maximum gives the value of a single saturating counter.
    assign lsum[l] = LSUM_W'(fwd[l][KIND_BYTE]) + LSUM_W'(fwd[l][KIND_CROSS]) +
                     LSUM_W'(fwd[l][KIND_HELD]);
    assign lclamp[l] = (lsum[l] > LSUM_W'(CNT_MAX)) ? CNT_MAX : lsum[l][COUNT_WIDTH-1:0];

    always_ff @(posedge clk) begin
      s_layer[l] <= lclamp[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_active <= 1'b1;
      sweep_init   <= 1'b1;
      sweep_row    <= '0;
      w_valid      <= 1'b0;
      s_valid      <= 1'b0;
    end else begin
      w_valid <= cmd_pop;
      s_valid <= w_is_read;
      if (sweep_active) begin
        sweep_row <= sweep_row + CELL_W'(1);
        if (sweep_row == CELL_W'(CELL_COUNT - 1)) begin
          sweep_active <= 1'b0;
          sweep_init   <= 1'b0;
        end
      end else if (cmd_pop && cmd.kind == CMD_CLEAR) begin
        sweep_active <= 1'b1;
        sweep_row    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_cmd <= cmd;
  end

  assign total = EXT_W'(s_layer[0]) + EXT_W'(s_layer[1]) + EXT_W'(s_layer[2]);

  always_comb begin
    case (readout_select)
      SEL_SUM: pick = total;
      SEL_L3:  pick = EXT_W'(s_layer[0]);
      SEL_L4:  pick = EXT_W'(s_layer[1]);
      SEL_L7:  pick = EXT_W'(s_layer[2]);
      default: pick = total;
    endcase
  end

  assign res_push = s_valid;
  assign res_data = (pick > EXT_W'(OUT_MAX)) ? OUT_MAX : pick[OUT_W-1:0];

endmodule
`default_nettype wire

// File: src/packet_nibble_bigram_histogram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Packet nibble bigram histogram
// Counts adjacent nibble pairs of tagged packet segments in three 16x16
// arrays of saturating counters and reads back single cells.
// ----------------------------------------------------------------------------
// Data and read transactions are taken one per cycle while in_ready is high;
// a read result passes the write and result registers into the output queue,
// where up to four results wait while the input keeps flowing. The rate is
// set by the counter RAMs: each layer keeps one RAM per pair kind, so every
// byte is one read-modify-write per RAM per cycle. A clear transaction
// sweeps all 256 cells of every counter RAM, during which queued
// transactions wait. After reset the same sweep runs with in_ready low;
// configuration writes are taken throughout.
module packet_nibble_bigram_histogram #(
  parameter int COUNT_WIDTH = pnbh_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [1:0]                 cfg_write_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 op,
  input  logic [7:0]                 data_byte,
  input  logic [1:0]                 layer,
  input  logic                       segment_start,
  input  logic [3:0]                 row_nibble,
  input  logic [3:0]                 col_nibble,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pnbh_pkg::OUT_W-1:0] pair_count
);

  import pnbh_pkg::*;

  logic [1:0]             readout_select;
  logic                   cmd_push;
  cmd_t                   cmd_in;
  logic [CMD_W-1:0]       cmd_raw;
  cmd_t                   cmd_head;
  logic                   cmd_full;
  logic                   cmd_empty;
  logic                   cmd_pop;
  logic                   init_busy;
  logic                   res_push;
  logic [OUT_W-1:0]       res_data;
  logic [OUT_COUNT_W-1:0] res_count;
  logic                   res_full;
  logic                   res_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      readout_select <= SEL_SUM;
    end else if (cfg_write_en) begin
      readout_select <= cfg_write_data;
    end
  end

  pnbh_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .data_byte     (data_byte),
    .layer         (layer),
    .segment_start (segment_start),
    .row_nibble    (row_nibble),
    .col_nibble    (col_nibble),
    .queue_full    (cmd_full),
    .init_busy     (init_busy),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in)
  );

  pnbh_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .pop       (cmd_pop),
    .pop_data  (cmd_raw),
    .count     (),
    .full      (cmd_full),
    .empty     (cmd_empty)
  );

  assign cmd_head = cmd_t'(cmd_raw);

  pnbh_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (!cmd_empty),
    .cmd            (cmd_head),
    .cmd_pop        (cmd_pop),
    .readout_select (readout_select),
    .res_count      (res_count),
    .res_push       (res_push),
    .res_data       (res_data),
    .init_busy      (init_busy)
  );

  pnbh_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .pop       (out_valid && out_ready),
    .pop_data  (pair_count),
    .count     (res_count),
    .full      (res_full),
    .empty     (res_empty)
  );

  assign out_valid = !res_empty;

  // The read credit must keep the output queue from overflowing.
  a_res_room: assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result pushed into a full output queue");

  a_cmd_room: assert property (@(posedge clk) disable iff (rst) cmd_push |-> !cmd_full)
    else $error("command pushed into a full command queue");

  // The counters are being cleared right after reset, so no transaction may enter.
  a_init_gate: assert property (@(posedge clk) $fell(rst) |-> !in_ready)
    else $error("input ready during the reset clearing sweep");

endmodule
`default_nettype wire

// File: tb/packet_nibble_bigram_histogram_tb.sv
// ----------------------------------------------------------------------------
// Packet nibble bigram histogram testbench
// Sends data, read, clear and unused-op transactions through the valid/ready
// input with random gaps. A built-in predictor keeps its own counter arrays
// and segment state and works out each read result, which the monitor checks
// in order under random output stalls. The readout register is rewritten
// between phases while the block is quiet. Counters are built 8 bits wide so
// that saturation is reached by long runs of one byte.
// ----------------------------------------------------------------------------
module packet_nibble_bigram_histogram_tb;
  import pnbh_pkg::*;

  localparam int COUNT_W       = 8;
  localparam int COUNT_MAX     = (1 << COUNT_W) - 1;
  localparam int SETTLE_CYCLES = 1500;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 250;
  localparam int PHASES        = 7;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] LAYER_L3  = 2'd0;
  localparam logic [1:0] LAYER_L4  = 2'd1;
  localparam logic [1:0] LAYER_L7  = 2'd2;

  typedef struct {
    logic [1:0] op;
    logic [7:0] data;
    logic [1:0] lay;
    logic       start;
    logic [3:0] row;
    logic [3:0] col;
    bit         drain;
  } hist_item_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write_en = 1'b0;
  logic [1:0]       cfg_write_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       op = '0;
  logic [7:0]       data_byte = '0;
  logic [1:0]       layer = '0;
  logic             segment_start = 1'b0;
  logic [3:0]       row_nibble = '0;
  logic [3:0]       col_nibble = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [OUT_W-1:0] pair_count;

  // Predictor state.
  int unsigned hist_count [NUM_LAYERS][SYMBOL_COUNT][SYMBOL_COUNT];
  logic [7:0]  held_byte   = '0;
  logic [3:0]  prev_lo     = '0;
  logic [1:0]  seg_phase   = PHASE_IDLE;
  logic [1:0]  seg_layer   = '0;
  logic [1:0]  readout_sel = SEL_SUM;

  hist_item_t       pending_items[$];
  logic [OUT_W-1:0] expected_counts[$];
  hist_item_t       cur_item;

  int   queued_total   = 0;
  int   accepted_total = 0;
  int   useful_items   = 0;
  int   mismatch_count = 0;
  int   cycle_count    = 0;
  int   send_wait      = 0;
  int   send_calm      = 0;
  int   recv_wait      = 0;
  int   recv_calm      = 0;
  logic [7:0] last_byte = '0;

  packet_nibble_bigram_histogram #(.COUNT_WIDTH(COUNT_W)) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .data_byte      (data_byte),
    .layer          (layer),
    .segment_start  (segment_start),
    .row_nibble     (row_nibble),
    .col_nibble     (col_nibble),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pair_count     (pair_count)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  function automatic void count_pair(logic [3:0] a, logic [3:0] b);
    if (seg_layer != LAYER_UNUSED && hist_count[seg_layer][a][b] < COUNT_MAX)
      hist_count[seg_layer][a][b]++;
  endfunction

  function automatic void update_histogram(hist_item_t it);
    logic [3:0]      hi;
    logic [3:0]      lo;
    longint unsigned total;
    hi = it.data[7:4];
    lo = it.data[3:0];
    case (it.op)
      OP_DATA: begin
        if (it.start || seg_phase == PHASE_IDLE) begin
          held_byte = it.data;
          prev_lo   = lo;
          seg_layer = it.lay;
          seg_phase = PHASE_HELD;
        end else if (seg_phase == PHASE_HELD) begin
          // The second byte of a segment also counts the pair of the held byte.
          count_pair(held_byte[7:4], held_byte[3:0]);
          count_pair(held_byte[3:0], hi);
          count_pair(hi, lo);
          prev_lo   = lo;
          seg_phase = PHASE_RUN;
        end else begin
          count_pair(prev_lo, hi);
          count_pair(hi, lo);
          prev_lo   = lo;
          seg_phase = PHASE_RUN;
        end
      end
      OP_READ: begin
        if (readout_sel == SEL_SUM)
          total = longint'(hist_count[0][it.row][it.col]) + hist_count[1][it.row][it.col]
                  + hist_count[2][it.row][it.col];
        else
          total = hist_count[readout_sel - 1][it.row][it.col];
        if (total > OUT_MAX) total = OUT_MAX;
        expected_counts.push_back(total[OUT_W-1:0]);
      end
      OP_CLEAR: begin
        foreach (hist_count[i, j, k]) hist_count[i][j][k] = 0;
      end
      default: ;
    endcase
  endfunction

  // Wait for one transaction: usually a random gap, at times a calm stretch with none.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic void add_item(logic [1:0] item_op, logic [7:0] item_data,
                                   logic [1:0] item_layer, logic item_start,
                                   logic [3:0] item_row, logic [3:0] item_col);
    hist_item_t it;
    it.op    = item_op;
    it.data  = item_data;
    it.lay   = item_layer;
    it.start = item_start;
    it.row   = item_row;
    it.col   = item_col;
    it.drain = 1'b0;
    pending_items.push_back(it);
    queued_total++;
    if (item_op != OP_UNUSED) useful_items++;
  endfunction

  function automatic void add_byte(logic [7:0] b, logic [1:0] l, logic s);
    add_item(OP_DATA, b, l, s, 4'($urandom), 4'($urandom));
    last_byte = b;
  endfunction

  function automatic void add_read(logic [3:0] r, logic [3:0] c);
    add_item(OP_READ, 8'($urandom), 2'($urandom), 1'($urandom), r, c);
  endfunction

  function automatic void add_clear();
    add_item(OP_CLEAR, 8'($urandom), 2'($urandom), 1'($urandom), 4'($urandom), 4'($urandom));
  endfunction

  function automatic void add_noop();
    add_item(OP_UNUSED, 8'($urandom), 2'($urandom), 1'($urandom), 4'($urandom),
             4'($urandom));
  endfunction

  // The sender holds the last queued transaction back until all results are in.
  function automatic void hold_until_drained();
    pending_items[pending_items.size() - 1].drain = 1'b1;
  endfunction

  // Reads mostly aim at cells that the recent bytes have touched.
  function automatic void add_aimed_read();
    if ($urandom_range(0, 1) == 0) add_read(last_byte[7:4], last_byte[3:0]);
    else if ($urandom_range(0, 1) == 0) add_read(last_byte[3:0], 4'($urandom));
    else add_read(4'($urandom), 4'($urandom));
  endfunction

  task automatic queue_random_traffic(int n_items);
    int         target;
    int         seg_len;
    int         pick;
    bit         long_run;
    logic [3:0] n;
    logic [7:0] b;
    logic [1:0] l;
    target = useful_items + n_items;
    while (useful_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        long_run = ($urandom_range(0, 39) == 0);
        seg_len  = long_run ? $urandom_range(60, 140) : $urandom_range(1, 10);
        l = ($urandom_range(0, 11) == 0) ? LAYER_UNUSED : 2'($urandom_range(0, 2));
        n = 4'($urandom);
        case ($urandom_range(0, 2))
          0:       b = 8'h00;
          1:       b = 8'hff;
          default: b = {n, n};
        endcase
        for (int k = 0; k < seg_len; k++) begin
          if (!long_run) b = 8'($urandom);
          if (k == 0) add_byte(b, l, $urandom_range(0, 9) != 0);
          else add_byte(b, 2'($urandom), $urandom_range(0, 29) == 0);
          if ($urandom_range(0, 6) == 0) add_aimed_read();
        end
        if (long_run) add_read(b[7:4], b[3:0]);
      end else if (pick < 88) begin
        add_aimed_read();
      end else if (pick < 91) begin
        add_clear();
      end else if (pick < 95) begin
        add_noop();
      end else begin
        add_byte(8'($urandom), 2'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 149) == 0) hold_until_drained();
    end
  endtask

  task automatic write_select(logic [1:0] sel);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= sel;
    readout_sel     = sel;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(negedge clk);
  endtask

  // A clear may still be sweeping with further transactions queued behind it
  // after the last result has come, so give it the full settle time.
  task automatic wait_quiet();
    do @(posedge clk);
    while (accepted_total != queued_total || expected_counts.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: presents queued transactions and feeds each accepted one to the
  // predictor.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        update_histogram(cur_item);
        accepted_total++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain && expected_counts.size() > 0)) begin
          cur_item       = pending_items.pop_front();
          op            <= cur_item.op;
          data_byte     <= cur_item.data;
          layer         <= cur_item.lay;
          segment_start <= cur_item.start;
          row_nibble    <= cur_item.row;
          col_nibble    <= cur_item.col;
          in_valid      <= 1'b1;
          send_wait      = draw_wait(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("pair_count %0d with no read outstanding", pair_count));
        end else begin
          if (pair_count !== expected_counts[0])
            report_mismatch($sformatf("pair_count %0d, expected %0d", pair_count,
                                      expected_counts[0]));
          void'(expected_counts.pop_front());
        end
        recv_wait = draw_wait(recv_calm);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("packet_nibble_bigram_histogram_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [1:0] phase_sel [PHASES];
    phase_sel = '{SEL_L7, SEL_L3, SEL_L4, SEL_SUM, SEL_L7, SEL_L4, SEL_L3};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_select(SEL_SUM);

    // Directed opening: an unmarked byte opens a segment, a lone byte counts
    // nothing, later layer tags are ignored, layer three counts nothing, and
    // reads and clears leave the open segment alone.
    add_byte(8'h00, LAYER_L3, 1'b0);
    add_read(4'h0, 4'h0);
    add_byte(8'hff, LAYER_L7, 1'b0);
    add_byte(8'h5a, LAYER_L4, 1'b0);
    add_read(4'h0, 4'h0);
    add_read(4'hf, 4'hf);
    add_read(4'hf, 4'h5);
    add_byte(8'hab, LAYER_UNUSED, 1'b1);
    add_byte(8'hcd, LAYER_L4, 1'b0);
    add_read(4'hb, 4'hc);
    add_byte(8'h12, LAYER_L4, 1'b1);
    hold_until_drained();
    add_read(4'h1, 4'h2);
    add_byte(8'h34, LAYER_L3, 1'b0);
    add_read(4'h2, 4'h3);
    add_noop();
    add_byte(8'hf0, LAYER_L7, 1'b1);
    add_byte(8'h0f, LAYER_L3, 1'b0);
    add_read(4'hf, 4'h0);
    add_byte(8'h21, LAYER_L3, 1'b1);
    add_clear();
    add_byte(8'h43, LAYER_L7, 1'b0);
    add_read(4'h1, 4'h4);
    add_read(4'h0, 4'hf);
    add_byte(8'hee, LAYER_L4, 1'b0);
    add_read(4'he, 4'he);

    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      write_select(phase_sel[p]);
      queue_random_traffic(PHASE_ITEMS);
    end
    wait_quiet();

    if (mismatch_count == 0) $display("packet_nibble_bigram_histogram_tb OK");
    else $display("packet_nibble_bigram_histogram_tb NOT OK");
    $finish;
  end

endmodule
